/* hw/rtl/qpn_pkg.sv */
// ----------------------------------------------------------------------------
// qpn_pkg: shared types and constants of the normalized quaternion product
// Beat types, widths and the queue depth between the front and back parts.
// ----------------------------------------------------------------------------
package qpn_pkg;

  localparam int FRAC_BITS = 14;
  localparam int CW        = 16;                  // component width
  localparam int PW        = 35;                  // product component width (signed)
  localparam int MW        = 34;                  // product magnitude width
  localparam int SW        = 70;                  // sum of squares width
  localparam int NW        = FRAC_BITS + 2;       // quotient bits incl. final round bit
  localparam int QDEPTH    = 2;
  localparam int QAW       = 1;

  typedef struct packed {
    logic               func;
    logic signed [15:0] a_w;
    logic signed [15:0] a_x;
    logic signed [15:0] a_y;
    logic signed [15:0] a_z;
    logic signed [15:0] b_w;
    logic signed [15:0] b_x;
    logic signed [15:0] b_y;
    logic signed [15:0] b_z;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] r_w;
    logic signed [15:0] r_x;
    logic signed [15:0] r_y;
    logic signed [15:0] r_z;
    logic               zero_magnitude;
  } out_beat_t;

  // beat handed from the front part to the back part
  typedef struct packed {
    logic [3:0]          neg;
    logic [3:0][MW-1:0]  mag;
    logic [SW-1:0]       sum;
  } work_t;

endpackage

/* hw/rtl/quaternion_product_normalize_unit.sv */
// ----------------------------------------------------------------------------
// quaternion_product_normalize_unit: normalized Hamilton product
// Top level: front (product, sum of squares), queue, back (normalize).
// ----------------------------------------------------------------------------
// One beat may be started every clock cycle; busy stays low. Each beat gives
// one result, shown for one cycle with out_valid after it passes 4 front
// stages, one queue write and a combinational queue read, the back's stage 0
// registers, 16 quotient stages (one bit per stage, the last one the
// rounding bit) and the output register. The receiver cannot stall, so the
// queue never backs up; it only decouples the two halves.
// Zero-magnitude products give zeros with zero_magnitude set.
// ----------------------------------------------------------------------------
module quaternion_product_normalize_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  qpn_pkg::in_beat_t   in_beat,
  output logic                out_valid,
  output qpn_pkg::out_beat_t  out_beat
);

  logic           f_valid, q_valid;
  qpn_pkg::work_t f_work, q_work;

  assign busy = 1'b0;

  qpn_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(start), .in_beat(in_beat),
    .out_valid(f_valid), .out_work(f_work)
  );

  qpn_queue u_queue (
    .clk(clk), .rst_n(rst_n), .wr_en(f_valid), .wr_data(f_work),
    .rd_en(q_valid), .rd_valid(q_valid), .rd_data(q_work)
  );

  qpn_back u_back (
    .clk(clk), .rst_n(rst_n), .in_valid(q_valid), .in_work(q_work),
    .out_valid(out_valid), .out_beat(out_beat)
  );

  // latency through the whole pipe is fixed
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 23)) else $error("result without start");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_beat.zero_magnitude) |-> (out_beat.r_w == 16'sd0))
    else $error("zero magnitude with nonzero w");
  a_noq: assert property (@(posedge clk) disable iff (!rst_n)
    f_valid |-> !busy) else $error("busy asserted");

endmodule

/* hw/rtl/qpn_front.sv */
// ----------------------------------------------------------------------------
// qpn_front: product front end
// Forms the Hamilton product B * A (or B * conj(A)) and its sum of squares
// over a four-stage pipeline.
// ----------------------------------------------------------------------------
module qpn_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  qpn_pkg::in_beat_t  in_beat,
  output logic               out_valid,
  output qpn_pkg::work_t     out_work
);

  localparam int PPW = 33;   // one partial product, 17x17 signed

  logic                        v1_r, v2_r, v3_r, v4_r;
  logic signed [3:0][3:0][PPW-1:0] pp_r;
  logic signed [3:0][qpn_pkg::PW-1:0] p_r;
  logic [3:0][qpn_pkg::MW-1:0] m2;
  logic [3:0]                  n2;
  logic [3:0][qpn_pkg::MW-1:0] mag_r;
  logic [3:0]                  neg_r;
  logic [3:0][2*qpn_pkg::MW-1:0] sq_r;
  logic [qpn_pkg::SW-1:0]      sum_r;
  logic [3:0][qpn_pkg::MW-1:0] mag3_r;
  logic [3:0]                  neg3_r;
  logic signed [16:0]          aw, ax, ay, az, bw, bx, by, bz;

  always_comb begin
    aw = 17'(in_beat.a_w);
    ax = in_beat.func ? -17'(in_beat.a_x) : 17'(in_beat.a_x);
    ay = in_beat.func ? -17'(in_beat.a_y) : 17'(in_beat.a_y);
    az = in_beat.func ? -17'(in_beat.a_z) : 17'(in_beat.a_z);
    bw = 17'(in_beat.b_w);
    bx = 17'(in_beat.b_x);
    by = 17'(in_beat.b_y);
    bz = 17'(in_beat.b_z);
  end

  // stage 1: sixteen partial products, sign folded in
  always_ff @(posedge clk) begin
    pp_r[0][0] <= PPW'(bw * aw);  pp_r[0][1] <= -PPW'(bx * ax);
    pp_r[0][2] <= -PPW'(by * ay); pp_r[0][3] <= -PPW'(bz * az);
    pp_r[1][0] <= PPW'(bw * ax);  pp_r[1][1] <= PPW'(bx * aw);
    pp_r[1][2] <= PPW'(by * az);  pp_r[1][3] <= -PPW'(bz * ay);
    pp_r[2][0] <= PPW'(bw * ay);  pp_r[2][1] <= PPW'(by * aw);
    pp_r[2][2] <= PPW'(bz * ax);  pp_r[2][3] <= -PPW'(bx * az);
    pp_r[3][0] <= PPW'(bw * az);  pp_r[3][1] <= PPW'(bz * aw);
    pp_r[3][2] <= PPW'(bx * ay);  pp_r[3][3] <= -PPW'(by * ax);
  end

  // stage 2: component sums (elements of a packed array read unsigned)
  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      p_r[i] <= qpn_pkg::PW'($signed(pp_r[i][0])) + qpn_pkg::PW'($signed(pp_r[i][1]))
              + qpn_pkg::PW'($signed(pp_r[i][2])) + qpn_pkg::PW'($signed(pp_r[i][3]));
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      n2[i] = p_r[i][qpn_pkg::PW-1];
      m2[i] = n2[i] ? qpn_pkg::MW'(-p_r[i]) : qpn_pkg::MW'(p_r[i]);
    end
  end

  // stage 3: magnitude and square
  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      sq_r[i] <= m2[i] * m2[i];
    end
    mag_r <= m2;
    neg_r <= n2;
  end

  // stage 4: sum of squares
  always_ff @(posedge clk) begin
    sum_r  <= qpn_pkg::SW'(sq_r[0]) + qpn_pkg::SW'(sq_r[1])
            + qpn_pkg::SW'(sq_r[2]) + qpn_pkg::SW'(sq_r[3]);
    mag3_r <= mag_r;
    neg3_r <= neg_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  assign out_valid    = v4_r;
  assign out_work.mag = mag3_r;
  assign out_work.neg = neg3_r;
  assign out_work.sum = sum_r;

endmodule

/* hw/rtl/qpn_queue.sv */
// ----------------------------------------------------------------------------
// qpn_queue: work queue
// Small FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module qpn_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  qpn_pkg::work_t  wr_data,
  input  logic            rd_en,
  output logic            rd_valid,
  output qpn_pkg::work_t  rd_data
);

  qpn_pkg::work_t              mem_r [qpn_pkg::QDEPTH];
  logic [qpn_pkg::QAW-1:0]     wp_r, rp_r;
  logic [qpn_pkg::QAW:0]       cnt_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (qpn_pkg::QAW+1)'(wr_en) - (qpn_pkg::QAW+1)'(rd_en);
    end
  end

  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];

endmodule

/* hw/rtl/qpn_back.sv */
// ----------------------------------------------------------------------------
// qpn_back: normalization back end
// One pipeline stage per quotient bit: finds n = floor(|p|*2^F/sqrt(S))
// with a running remainder T - q^2*S and running q*S (shifts and adds
// only), then rounds with the half bit.
// ----------------------------------------------------------------------------
module qpn_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  qpn_pkg::work_t      in_work,
  output logic                out_valid,
  output qpn_pkg::out_beat_t  out_beat
);

  localparam int NS  = qpn_pkg::NW;                    // quotient stages
  localparam int TW  = 2*qpn_pkg::MW + 2*qpn_pkg::FRAC_BITS + 2;
  localparam int QSW = NS + qpn_pkg::SW;
  localparam int CMW = 2*NS + qpn_pkg::SW;

  // per stage: remainder R = 4*p^2*4^F - q^2*S, qs = q*S, doubled quotient q
  // (so the final bit is the round bit)
  logic [NS:0]                          v_r;
  logic [NS:0]                          neg_r [4];
  logic [NS:0][qpn_pkg::SW-1:0]         s_r;
  logic [TW-1:0]                        rem_r [NS][4];
  logic [QSW-1:0]                       qs_r  [NS][4];
  logic [NS-1:0]                        q_r   [NS+1][4];
  logic [NS:0]                          z_r;

  // stage 0 registers
  always_ff @(posedge clk) begin
    s_r[0] <= in_work.sum;
    z_r[0] <= (in_work.sum == '0);
  end

  for (genvar i = 0; i < 4; i++) begin : g_in
    logic [2*qpn_pkg::MW-1:0] msq;
    assign msq = in_work.mag[i] * in_work.mag[i];
    always_ff @(posedge clk) begin
      rem_r[0][i] <= TW'(msq) << (2*qpn_pkg::FRAC_BITS + 2);
      qs_r[0][i]  <= '0;
      q_r[0][i]   <= '0;
      neg_r[i][0] <= in_work.neg[i];
    end
  end

  // quotient stages: q counts in halves; bit B of q per stage, MSB first.
  // Taking bit B costs (q*S << (B+1)) + (S << 2B) of the remainder.
  for (genvar k = 0; k < NS; k++) begin : g_stg
    localparam int B = NS - 1 - k;
    for (genvar i = 0; i < 4; i++) begin : g_c
      logic [CMW-1:0] delta;
      logic           take;
      assign delta = (CMW'(qs_r[k][i]) << (B + 1)) + (CMW'(s_r[k]) << (2 * B));
      assign take  = (delta <= CMW'(rem_r[k][i]));
      always_ff @(posedge clk) begin
        q_r[k+1][i]   <= take ? (q_r[k][i] | (NS'(1) << B)) : q_r[k][i];
        neg_r[i][k+1] <= neg_r[i][k];
      end
      if (k + 1 < NS) begin : g_nx
        always_ff @(posedge clk) begin
          rem_r[k+1][i] <= take ? (rem_r[k][i] - TW'(delta)) : rem_r[k][i];
          qs_r[k+1][i]  <= take ? (qs_r[k][i] + (QSW'(s_r[k]) << B)) : qs_r[k][i];
        end
      end
    end
    always_ff @(posedge clk) begin
      s_r[k+1] <= s_r[k];
      z_r[k+1] <= z_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[NS-1:0], in_valid};
    end
  end

  // q = 2n or 2n+1; rounded n' = floor(q/2) + q[0] = (q+1)>>1
  logic [NS:0]         rn [4];
  logic signed [NS+1:0] sv [4];
  logic [15:0]         rc [4];
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rn[i] = ((NS+1)'(q_r[NS][i]) + (NS+1)'(1)) >> 1;
      sv[i] = neg_r[i][NS] ? -(NS+2)'(rn[i]) : (NS+2)'(rn[i]);
      if (z_r[NS])            rc[i] = '0;
      else if (sv[i] > 32767)  rc[i] = 16'h7fff;
      else if (sv[i] < -32768) rc[i] = 16'h8000;
      else                    rc[i] = sv[i][15:0];
    end
  end

  always_ff @(posedge clk) begin
    out_beat.r_w <= rc[0];
    out_beat.r_x <= rc[1];
    out_beat.r_y <= rc[2];
    out_beat.r_z <= rc[3];
    out_beat.zero_magnitude <= z_r[NS];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v_r[NS];
    end
  end

endmodule

/* tb/qpn_result_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// qpn_result_checker: scoreboard of the normalized quaternion product
// Predicts each accepted input beat and compares result beats in order.
// ----------------------------------------------------------------------------
module qpn_result_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  qpn_pkg::in_beat_t  in_beat,
  input  logic               out_valid,
  input  qpn_pkg::out_beat_t out_beat,
  output int                 fails,
  output int                 pending
);

  typedef logic [159:0] big_t;

  qpn_pkg::out_beat_t unit_queue[$];

  // exact round(|p| * 2^F / sqrt(s)), sign of p, saturated to 16 bits
  function automatic logic signed [15:0] scale_comp(longint p, big_t s);
    big_t mag, t, cand, n, prod;
    longint r;
    mag = (p < 0) ? big_t'(-p) : big_t'(p);
    t = (mag * mag) << (2 * qpn_pkg::FRAC_BITS);
    n = '0;
    for (int k = qpn_pkg::FRAC_BITS; k >= 0; k--) begin
      cand = n | (big_t'(1) << k);
      prod = cand * cand * s;
      if (prod <= t) n = cand;
    end
    cand = 2 * n + 1;
    prod = cand * cand * s;
    if (prod <= (t << 2)) n = n + 1;
    r = (p < 0) ? -longint'(n) : longint'(n);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic qpn_pkg::out_beat_t unit_product(qpn_pkg::in_beat_t b);
    longint aw, ax, ay, az, bw, bx, by, bz;
    longint p[4];
    big_t s, m;
    qpn_pkg::out_beat_t r;
    aw = b.a_w; ax = b.a_x; ay = b.a_y; az = b.a_z;
    bw = b.b_w; bx = b.b_x; by = b.b_y; bz = b.b_z;
    if (b.func) begin
      ax = -ax; ay = -ay; az = -az;   // -32768 becomes +32768, no wrap
    end
    p[0] = bw * aw - bx * ax - by * ay - bz * az;
    p[1] = bw * ax + bx * aw + by * az - bz * ay;
    p[2] = bw * ay + by * aw + bz * ax - bx * az;
    p[3] = bw * az + bz * aw + bx * ay - by * ax;
    s = '0;
    for (int i = 0; i < 4; i++) begin
      m = (p[i] < 0) ? big_t'(-p[i]) : big_t'(p[i]);
      s = s + m * m;
    end
    r = '0;
    if (s == 0) begin
      r.zero_magnitude = 1'b1;
    end else begin
      r.r_w = scale_comp(p[0], s);
      r.r_x = scale_comp(p[1], s);
      r.r_y = scale_comp(p[2], s);
      r.r_z = scale_comp(p[3], s);
    end
    return r;
  endfunction

  initial fails = 0;

  always @(posedge clk) begin
    qpn_pkg::out_beat_t want;
    if (rst_n) begin
      if (start && !busy) unit_queue.push_back(unit_product(in_beat));
      if (out_valid) begin
        if (unit_queue.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_beat);
          fails++;
        end else begin
          want = unit_queue.pop_front();
          if (want.r_w !== out_beat.r_w || want.r_x !== out_beat.r_x ||
              want.r_y !== out_beat.r_y || want.r_z !== out_beat.r_z ||
              want.zero_magnitude !== out_beat.zero_magnitude) begin
            $display("%0t: mismatch expected w=%0d x=%0d y=%0d z=%0d zm=%0b",
                     $time, want.r_w, want.r_x, want.r_y, want.r_z,
                     want.zero_magnitude);
            $display("%0t:          actual   w=%0d x=%0d y=%0d z=%0d zm=%0b",
                     $time, out_beat.r_w, out_beat.r_x, out_beat.r_y,
                     out_beat.r_z, out_beat.zero_magnitude);
            fails++;
          end
        end
      end
    end
    pending = unit_queue.size();
  end
endmodule

/* tb/tb_quaternion_product_normalize_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_quaternion_product_normalize_unit: stimulus and verdict
// Directed corner beats, then random beats with random gaps; a checker
// beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_quaternion_product_normalize_unit;

  localparam int IDLE_LIMIT = 5000;   // cycles with no beat moving
  localparam int DRAIN      = 40;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  qpn_pkg::in_beat_t  in_beat = '0;
  logic               out_valid;
  qpn_pkg::out_beat_t out_beat;
  int                 fails;
  int                 pending;
  int                 idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  quaternion_product_normalize_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_beat(in_beat), .out_valid(out_valid), .out_beat(out_beat)
  );

  qpn_result_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_beat(in_beat),
    .out_valid(out_valid), .out_beat(out_beat), .fails(fails), .pending(pending)
  );

  // watchdog: any beat moving restarts the count
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  bit no_gaps = 1'b0;

  // gap before a beat: mostly none or short, a few long; start drops in a gap
  task automatic idle_gap();
    int g, r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) g = 0;
    else if (r < 92) g = $urandom_range(1, 3);
    else g = $urandom_range(10, 60);
    if (g > 0) start <= 1'b0;
    repeat (g) @(negedge clk);
  endtask

  // send one beat; start stays high across back-to-back beats
  task automatic send_beat(qpn_pkg::in_beat_t b);
    idle_gap();
    in_beat <= b;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [15:0] rnd_comp(int kind);
    case (kind)
      0: return 16'($urandom());
      1: return 16'($urandom_range(0, 15) - 8);               // tiny
      2: return ($urandom_range(0, 1)) ? 16'sh8000 : 16'sh7fff;
      3: return ($urandom_range(0, 1)) ? 16'sd16384 : -16'sd16384;
      default: return 16'h0000;
    endcase
  endfunction

  function automatic qpn_pkg::in_beat_t rnd_beat();
    qpn_pkg::in_beat_t b;
    int mode;
    mode = $urandom_range(0, 9);
    b.func = 1'($urandom_range(0, 1));
    if (mode < 6) begin
      {b.a_w, b.a_x, b.a_y, b.a_z} = {$urandom(), $urandom()};
      {b.b_w, b.b_x, b.b_y, b.b_z} = {$urandom(), $urandom()};
    end else begin
      // mixed corner components, zeros included
      b.a_w = rnd_comp($urandom_range(0, 4)); b.a_x = rnd_comp($urandom_range(0, 4));
      b.a_y = rnd_comp($urandom_range(0, 4)); b.a_z = rnd_comp($urandom_range(0, 4));
      b.b_w = rnd_comp($urandom_range(0, 4)); b.b_x = rnd_comp($urandom_range(0, 4));
      b.b_y = rnd_comp($urandom_range(0, 4)); b.b_z = rnd_comp($urandom_range(0, 4));
      if (mode == 9) {b.b_w, b.b_x, b.b_y, b.b_z} = '0;       // zero product
    end
    return b;
  endfunction

  function automatic qpn_pkg::in_beat_t mk(logic f, logic [15:0] aw, ax, ay, az,
                                           logic [15:0] bw, bx, by, bz);
    qpn_pkg::in_beat_t b;
    b.func = f;
    b.a_w = aw; b.a_x = ax; b.a_y = ay; b.a_z = az;
    b.b_w = bw; b.b_x = bx; b.b_y = by; b.b_z = bz;
    return b;
  endfunction

  initial begin
    int waited;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: identities, zeros, extremes, negated -2.0 in delta mode
    send_beat(mk(0, 16384, 0, 0, 0, 16384, 0, 0, 0));
    send_beat(mk(1, 16384, 0, 0, 0, 16384, 0, 0, 0));
    send_beat(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_beat(mk(1, 0, 0, 0, 0, 1, 2, 3, 4));
    send_beat(mk(0, 1, 2, 3, 4, 0, 0, 0, 0));
    send_beat(mk(0, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                 16'h8000, 16'h8000, 16'h8000, 16'h8000));
    send_beat(mk(1, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                 16'h8000, 16'h8000, 16'h8000, 16'h8000));
    send_beat(mk(0, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
    send_beat(mk(1, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                 16'h8000, 16'h7fff, 16'h8000, 16'h7fff));
    send_beat(mk(0, 0, 16384, 0, 0, 0, 0, 16384, 0));
    send_beat(mk(1, 0, 0, 0, 16384, 0, 16384, 0, 0));
    send_beat(mk(0, 1, 0, 0, 0, 1, 0, 0, 0));             // smallest magnitude
    send_beat(mk(0, 16'hffff, 0, 0, 0, 0, 1, 0, 0));
    send_beat(mk(1, 3, 0, 4, 0, 1, 0, 0, 0));             // 3-4-5 ratios
    send_beat(mk(0, 1, 1, 0, 0, 1, 0, 0, 0));             // 1/sqrt2 rounding
    send_beat(mk(1, 16'h8000, 0, 0, 0, 0, 16'h8000, 0, 0));
    send_beat(mk(0, 1, 1, 1, 1, 1, 0, 0, 0));             // exact half
    send_beat(mk(1, 11585, 11585, 0, 0, 11585, 0, 11585, 0));

    // random, with some gap-free stretches
    for (int i = 0; i < 1600; i++) begin
      if (i % 200 == 0) no_gaps = ($urandom_range(0, 2) == 0);
      send_beat(rnd_beat());
    end
    start <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < 10 * DRAIN) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
